/* src/bls_pkg.sv */
`default_nettype none
package bls_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned COLOR_BITS = 24;
  // Error term spans -2*major .. 2*minor, plus sign and headroom.
  localparam int unsigned DEC_BITS   = COORD_BITS + 3;

  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_BITS  = 1;
  localparam int unsigned QCNT_BITS  = QPTR_BITS + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  // Classified command word passed from the front to the back.
  typedef struct packed {
    logic   load;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t color;
    coord_t delta_major;
    coord_t delta_minor;
    dec_t   dec_init;
    logic   neg_x;
    logic   neg_y;
    logic   major_is_y;
  } cmd_t;

  function automatic coord_t move_one(input coord_t v, input logic neg);
    coord_t r;
    if (neg) begin
      r = v - coord_t'(1);
    end else begin
      r = v + coord_t'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/bresenham_line_stepper_top.sv */
`default_nettype none
// Channel | Handshake                | Word
// --------+--------------------------+-------------------------------------------
// input   | in_valid_i / in_ready_o  | load, start_x/y, end_x/y, line_color
// output  | out_valid_o / out_ready_i| pixel_x/y, pixel_color, last_pixel
//
// Sustained rate is one word per clock in and at most one pixel per clock out,
// when the output is not stalled. A word is stored in the queue; its pixel is then registered.
// The stepper (one compare and one add per pixel) sets the one-word-per-cycle
// figure; the two-entry queue lets the front keep accepting while the output
// is stalled, and in_ready_o drops only once the queue is full.
// rst_ni (async, active low) empties the queue, clears line state, drops out_valid_o.
module bresenham_line_stepper_top (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            load_i,
  input  wire bls_pkg::coord_t start_x_i,
  input  wire bls_pkg::coord_t start_y_i,
  input  wire bls_pkg::coord_t end_x_i,
  input  wire bls_pkg::coord_t end_y_i,
  input  wire bls_pkg::color_t line_color_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output bls_pkg::coord_t      pixel_x_o,
  output bls_pkg::coord_t      pixel_y_o,
  output bls_pkg::color_t      pixel_color_o,
  output logic                 last_pixel_o
);
  import bls_pkg::*;

  cmd_t front_cmd, head_cmd;
  logic q_full, q_push, q_pop, head_valid;

  assign in_ready_o = !q_full;
  assign q_push     = in_valid_i && !q_full;

  // front: classify the word and do line setup
  bls_front u_front (
    .load_i       (load_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .line_color_i (line_color_i),
    .cmd_o        (front_cmd)
  );

  // queue decouples setup from stepping
  bls_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_cmd_i   (front_cmd),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  // back: Bresenham stepper and output register
  bls_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_cmd_i    (head_cmd),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule
`default_nettype wire

/* src/bls_front.sv */
`default_nettype none
// Line setup: step directions, absolute deltas, major axis, initial error term.
module bls_front (
  input  wire logic            load_i,
  input  wire bls_pkg::coord_t start_x_i,
  input  wire bls_pkg::coord_t start_y_i,
  input  wire bls_pkg::coord_t end_x_i,
  input  wire bls_pkg::coord_t end_y_i,
  input  wire bls_pkg::color_t line_color_i,
  output bls_pkg::cmd_t        cmd_o
);
  import bls_pkg::*;

  logic   neg_x, neg_y, major_y;
  coord_t adx, ady, dmaj, dmin;

  always_comb begin
    neg_x   = end_x_i < start_x_i;
    neg_y   = end_y_i < start_y_i;
    adx     = neg_x ? (start_x_i - end_x_i) : (end_x_i - start_x_i);
    ady     = neg_y ? (start_y_i - end_y_i) : (end_y_i - start_y_i);
    major_y = ady > adx;  // ties go to x
    dmaj    = major_y ? ady : adx;
    dmin    = major_y ? adx : ady;

    cmd_o.load        = load_i;
    cmd_o.start_x     = start_x_i;
    cmd_o.start_y     = start_y_i;
    cmd_o.end_x       = end_x_i;
    cmd_o.end_y       = end_y_i;
    cmd_o.color       = line_color_i;
    cmd_o.delta_major = dmaj;
    cmd_o.delta_minor = dmin;
    cmd_o.dec_init    = (dec_t'(dmin) <<< 1) - dec_t'(dmaj);
    cmd_o.neg_x       = neg_x;
    cmd_o.neg_y       = neg_y;
    cmd_o.major_is_y  = major_y;
  end

endmodule
`default_nettype wire

/* src/bls_queue.sv */
`default_nettype none
// Small command queue between front and back.
module bls_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire bls_pkg::cmd_t push_cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               head_valid_o,
  output bls_pkg::cmd_t      head_cmd_o
);
  import bls_pkg::*;

  cmd_t                 mem_q [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0] cnt_q, cnt_d;

  assign full_o       = cnt_q == QCNT_BITS'(QDEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_BITS'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

/* src/bls_back.sv */
`default_nettype none
// Stepper: holds line state, executes one command word per cycle unless
// the output register is stalled, drives the registered output word.
module bls_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            head_valid_i,
  input  wire bls_pkg::cmd_t   head_cmd_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output bls_pkg::coord_t      pixel_x_o,
  output bls_pkg::coord_t      pixel_y_o,
  output bls_pkg::color_t      pixel_color_o,
  output logic                 last_pixel_o
);
  import bls_pkg::*;

  coord_t cur_x_q, cur_y_q, tgt_x_q, tgt_y_q, maj_q, min_q;
  dec_t   dec_q;
  logic   neg_x_q, neg_y_q, major_y_q, active_q;
  color_t color_q;

  // effective state: command fields on a load, registers otherwise
  coord_t e_cx, e_cy, e_tx, e_ty, e_maj, e_min;
  dec_t   e_dec;
  logic   e_nx, e_ny, e_my, e_act;
  color_t e_col;

  coord_t maj_cur, maj_next, min_cur, min_next, maj_tgt;
  coord_t cx_d, cy_d;
  dec_t   dec_d;
  logic   act_d, last, step_min, emit;

  logic   out_valid_q;
  coord_t px_q, py_q;
  color_t pc_q;
  logic   pl_q;

  assign pop_o = head_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    if (head_cmd_i.load) begin
      e_cx  = head_cmd_i.start_x;
      e_cy  = head_cmd_i.start_y;
      e_tx  = head_cmd_i.end_x;
      e_ty  = head_cmd_i.end_y;
      e_maj = head_cmd_i.delta_major;
      e_min = head_cmd_i.delta_minor;
      e_dec = head_cmd_i.dec_init;
      e_nx  = head_cmd_i.neg_x;
      e_ny  = head_cmd_i.neg_y;
      e_my  = head_cmd_i.major_is_y;
      e_col = head_cmd_i.color;
      e_act = head_cmd_i.delta_major != '0;  // zero length: nothing plotted
    end else begin
      e_cx  = cur_x_q;
      e_cy  = cur_y_q;
      e_tx  = tgt_x_q;
      e_ty  = tgt_y_q;
      e_maj = maj_q;
      e_min = min_q;
      e_dec = dec_q;
      e_nx  = neg_x_q;
      e_ny  = neg_y_q;
      e_my  = major_y_q;
      e_col = color_q;
      e_act = active_q;
    end

    maj_cur  = e_my ? e_cy : e_cx;
    min_cur  = e_my ? e_cx : e_cy;
    maj_tgt  = e_my ? e_ty : e_tx;
    maj_next = move_one(maj_cur, e_my ? e_ny : e_nx);
    min_next = move_one(min_cur, e_my ? e_nx : e_ny);
    last     = maj_next == maj_tgt;
    step_min = !e_dec[DEC_BITS-1];
    emit     = pop_o && e_act;

    cx_d  = e_cx;
    cy_d  = e_cy;
    dec_d = e_dec;
    act_d = e_act;
    if (e_act) begin
      if (e_my) begin
        cy_d = maj_next;
        cx_d = step_min ? min_next : e_cx;
      end else begin
        cx_d = maj_next;
        cy_d = step_min ? min_next : e_cy;
      end
      if (step_min) begin
        dec_d = e_dec + (dec_t'(e_min) <<< 1) - (dec_t'(e_maj) <<< 1);
      end else begin
        dec_d = e_dec + (dec_t'(e_min) <<< 1);
      end
      act_d = !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      tgt_x_q   <= '0;
      tgt_y_q   <= '0;
      maj_q     <= '0;
      min_q     <= '0;
      dec_q     <= '0;
      neg_x_q   <= 1'b0;
      neg_y_q   <= 1'b0;
      major_y_q <= 1'b0;
      color_q   <= '0;
      active_q  <= 1'b0;
    end else if (pop_o) begin
      cur_x_q   <= cx_d;
      cur_y_q   <= cy_d;
      tgt_x_q   <= e_tx;
      tgt_y_q   <= e_ty;
      maj_q     <= e_maj;
      min_q     <= e_min;
      dec_q     <= dec_d;
      neg_x_q   <= e_nx;
      neg_y_q   <= e_ny;
      major_y_q <= e_my;
      color_q   <= e_col;
      active_q  <= act_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      px_q <= e_cx;
      py_q <= e_cy;
      pc_q <= e_col;
      pl_q <= last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pc_q;
  assign last_pixel_o  = pl_q;

endmodule
`default_nettype wire
